// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted (active low).
`define R2HSL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds through reset.
`define R2HSL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/r2hsl_pkg.sv =====
// Types and constants of the RGB to HSL pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package r2hsl_pkg;

    localparam int FIELD_W    = 17;                    // width of every result field
    localparam int QUO_W      = 18;                    // quotient bits, one spare on top
    localparam int DIV_STEPS  = 3;                     // restoring steps per divider stage
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;     // divider pipeline depth
    localparam int PIPE_STAGES = DIV_STAGES + 2;       // plus extrema and prep stages

    // Hue offsets in degrees, applied as K * delta
    localparam logic [8:0] HUE_K_RED_WRAP = 9'd360;
    localparam logic [8:0] HUE_K_GREEN    = 9'd120;
    localparam logic [8:0] HUE_K_BLUE     = 9'd240;
    localparam logic [15:0] HUE_SLOPE     = 16'd60;

    // Saturation denominator folds around the midpoint of max + min
    localparam logic [8:0] SUM_MID  = 9'd255;
    localparam logic [8:0] SUM_FULL = 9'd510;

    typedef enum logic [1:0] {
        BR_RED,
        BR_GREEN,
        BR_BLUE
    } t_branch;

    // Output of the extrema stage
    typedef struct packed {
        t_branch           branch;
        logic signed [8:0] diff;    // channel difference of the chosen hue branch
        logic [7:0]        delta;   // max - min
        logic [8:0]        sum;     // max + min
    } t_ext;

    // One restoring divider in flight: partial remainder, dividend bits
    // shifting out at the top while quotient bits shift in at the bottom
    typedef struct packed {
        logic [7:0]       rem;
        logic [QUO_W-1:0] work;
        logic [7:0]       divisor;
    } t_div_lane;

    typedef struct packed {
        t_div_lane          hue;
        t_div_lane          sat;
        logic [FIELD_W-1:0] light;
    } t_div_word;

endpackage

`default_nettype wire

// ===== rtl/core/rgb_to_hsl_converter.sv =====
// Top level of the RGB to HSL converter: valid/ready wrapper around the pipeline.
// Depends on r2hsl_pkg, r2hsl_extrema, r2hsl_prep, r2hsl_div_stage.
//
// Usage:
//   Input channel i_valid / o_ready / i_argb_word carries one packed ARGB
//   pixel per transaction; alpha (bits 31-24) is ignored.
//   Output channel o_valid / i_ready carries hue (degrees * 256), saturation
//   and lightness (65536 = 1.0), all truncated.
//   From input transaction to o_valid, the transaction loads the extrema
//   stage, then passes one prep stage and six divider stages of three
//   restoring steps each (18 quotient bits for both dividers).
//   Throughput is one pixel per cycle; every stage has its own valid bit, so
//   the dividers are the depth, not the rate.
//   When the receiver stalls, the last stage holds its transaction and the
//   stall reaches back at once to the first empty stage, which keeps filling,
//   so inputs are still taken until the pipeline is full. Nothing is dropped
//   or repeated. o_ready depends combinationally on i_ready.
//   Synchronous active-low reset clears all valid bits; payload registers are
//   not reset.
`default_nettype none

module rgb_to_hsl_converter
    import r2hsl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [31:0]        i_argb_word,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [FIELD_W-1:0]      o_hue_deg_q8,
    output logic [FIELD_W-1:0]      o_saturation_q16,
    output logic [FIELD_W-1:0]      o_lightness_q16
);

    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] n_valid;
    logic [PIPE_STAGES:0]   stg_ready;
    t_ext                   ext_word;
    t_div_word              div_word [0:DIV_STAGES];

    // A stage can load when it is empty or its content moves on this cycle
    always_comb begin
        stg_ready[PIPE_STAGES] = i_ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            stg_ready[k] = !r_valid[k] || stg_ready[k+1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (stg_ready[0]) begin
            n_valid[0] = i_valid;
        end
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (stg_ready[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Stage 0: max, min, hue branch
    r2hsl_extrema u_extrema (
        .i_clk       (i_clk),
        .i_en        (stg_ready[0]),
        .i_argb_word (i_argb_word),
        .o_ext       (ext_word)
    );

    // Stage 1: dividends, divisors, lightness
    r2hsl_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (stg_ready[1]),
        .i_ext  (ext_word),
        .o_word (div_word[0])
    );

    // Stages 2 and up: divider steps
    for (genvar gi = 0; gi < DIV_STAGES; gi++) begin : g_div
        r2hsl_div_stage u_div_stage (
            .i_clk  (i_clk),
            .i_en   (stg_ready[gi+2]),
            .i_word (div_word[gi]),
            .o_word (div_word[gi+1])
        );
    end

    assign o_ready          = stg_ready[0];
    assign o_valid          = r_valid[PIPE_STAGES-1];
    // top quotient bit is always zero: results stay below 2^17
    assign o_hue_deg_q8     = div_word[DIV_STAGES].hue.work[FIELD_W-1:0];
    assign o_saturation_q16 = div_word[DIV_STAGES].sat.work[FIELD_W-1:0];
    assign o_lightness_q16  = div_word[DIV_STAGES].light;

endmodule

`default_nettype wire

// ===== rtl/core/r2hsl_extrema.sv =====
// Extrema stage: unpacks the pixel, finds max, min and the hue branch.
// Depends on r2hsl_pkg.
`default_nettype none

module r2hsl_extrema
    import r2hsl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_argb_word,
    output t_ext             o_ext
);

    logic [7:0] red, green, blue;
    logic [7:0] ch_max, ch_min;
    t_ext       n_ext;
    t_ext       r_ext;

    assign red   = i_argb_word[23:16];
    assign green = i_argb_word[15:8];
    assign blue  = i_argb_word[7:0];

    always_comb begin
        // red wins ties, then green
        if (red >= green && red >= blue) begin
            n_ext.branch = BR_RED;
            ch_max       = red;
            n_ext.diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
        end else if (green >= blue) begin
            n_ext.branch = BR_GREEN;
            ch_max       = green;
            n_ext.diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
        end else begin
            n_ext.branch = BR_BLUE;
            ch_max       = blue;
            n_ext.diff   = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        ch_min      = (red <= green) ? ((red <= blue) ? red : blue)
                                     : ((green <= blue) ? green : blue);
        n_ext.delta = ch_max - ch_min;
        n_ext.sum   = {1'b0, ch_max} + {1'b0, ch_min};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ext <= n_ext;
        end
    end

    assign o_ext = r_ext;

endmodule

`default_nettype wire

// ===== rtl/core/r2hsl_prep.sv =====
// Prep stage: builds hue and saturation dividends and divisors, lightness.
// Depends on r2hsl_pkg.
`default_nettype none

module r2hsl_prep
    import r2hsl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_ext i_ext,
    output t_div_word o_word
);

    logic [8:0]         hue_k;
    logic [16:0]        k_delta;
    logic [15:0]        slope_diff;
    logic [17:0]        hue_sum;
    logic [16:0]        hue_num;     // hue * delta, always >= 0
    logic [8:0]         den_wide;
    logic               grey;
    logic [15:0]        light_y;
    logic [16:0]        light_z;
    logic [16:0]        light_w;
    t_div_word          n_word;
    t_div_word          r_word;

    always_comb begin
        case (i_ext.branch)
            BR_RED:   hue_k = i_ext.diff[8] ? HUE_K_RED_WRAP : 9'd0;
            BR_GREEN: hue_k = HUE_K_GREEN;
            BR_BLUE:  hue_k = HUE_K_BLUE;
            default:  hue_k = 9'd0;
        endcase
    end

    assign grey       = (i_ext.delta == 8'd0);
    assign k_delta    = 17'({8'd0, hue_k} * {9'd0, i_ext.delta});
    assign slope_diff = {{7{i_ext.diff[8]}}, i_ext.diff} * HUE_SLOPE;
    assign hue_sum    = {1'b0, k_delta} + {{2{slope_diff[15]}}, slope_diff};
    assign hue_num    = grey ? 17'd0 : hue_sum[16:0];
    assign den_wide   = (i_ext.sum >= SUM_MID) ? (SUM_FULL - i_ext.sum) : i_ext.sum;

    // s * 65536 / 510 = 128*s + floor(128*s / 255), the last by reciprocal
    assign light_y = {i_ext.sum, 7'd0};
    assign light_z = {1'b0, light_y} + 17'd1;
    assign light_w = light_z + {8'd0, light_z[16:8]};

    always_comb begin
        // hue dividend is hue_num << 8, saturation dividend is delta << 16;
        // preload the bits above the quotient window as the remainder
        n_word.hue.rem     = {1'b0, hue_num[16:10]};
        n_word.hue.work    = {hue_num[9:0], 8'd0};
        n_word.hue.divisor = grey ? 8'd1 : i_ext.delta;
        n_word.sat.rem     = grey ? 8'd0 : {2'd0, i_ext.delta[7:2]};
        n_word.sat.work    = grey ? '0 : {i_ext.delta[1:0], 16'd0};
        n_word.sat.divisor = grey ? 8'd1 : den_wide[7:0];
        n_word.light       = {1'b0, light_y} + {8'd0, light_w[16:8]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ===== rtl/core/r2hsl_div_stage.sv =====
// One stage of the two restoring dividers; carries lightness along.
// Depends on r2hsl_pkg.
`default_nettype none

module r2hsl_div_stage
    import r2hsl_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_en,
    input  wire t_div_word i_word,
    output t_div_word      o_word
);

    t_div_word n_word;
    t_div_word r_word;

    function automatic t_div_lane div_step(input t_div_lane x);
        logic [8:0] trial;
        t_div_lane  y;
        y     = x;
        trial = {x.rem, x.work[QUO_W-1]};
        if (trial >= {1'b0, x.divisor}) begin
            y.rem  = 8'(trial - {1'b0, x.divisor});
            y.work = {x.work[QUO_W-2:0], 1'b1};
        end else begin
            y.rem  = trial[7:0];
            y.work = {x.work[QUO_W-2:0], 1'b0};
        end
        return y;
    endfunction

    always_comb begin
        n_word = i_word;
        for (int i = 0; i < DIV_STEPS; i++) begin
            n_word.hue = div_step(n_word.hue);
            n_word.sat = div_step(n_word.sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ===== rtl/core/r2hsl_checker.sv =====
// Port-level assertions for rgb_to_hsl_converter, attached by bind.
// Depends on r2hsl_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module r2hsl_checker
    import r2hsl_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic [FIELD_W-1:0] o_hue_deg_q8,
    input wire logic [FIELD_W-1:0] o_saturation_q16,
    input wire logic [FIELD_W-1:0] o_lightness_q16
);

    logic [3*FIELD_W-1:0] out_fields;

    assign out_fields = {o_hue_deg_q8, o_saturation_q16, o_lightness_q16};

    property p_out_hold;
        o_valid && !i_ready |=> o_valid && $stable(out_fields);
    endproperty

    property p_out_range;
        o_valid |-> o_hue_deg_q8 < 17'd92160 && o_saturation_q16 <= 17'd65536
                    && o_lightness_q16 <= 17'd65536;
    endproperty

    property p_grey_hue;
        o_valid && o_saturation_q16 == 17'd0 |-> o_hue_deg_q8 == 17'd0;
    endproperty

    // Hold a stalled result unchanged
    `R2HSL_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "stalled result changed")

    // Every result field stays in range
    `R2HSL_ASSERT(a_out_range, i_clk, i_rst_n, p_out_range, "result field out of range")

    // Zero saturation only comes from a grey pixel, whose hue is zero
    `R2HSL_ASSERT(a_grey_hue, i_clk, i_rst_n, p_grey_hue, "grey pixel with nonzero hue")

    // Drop all transactions on reset
    `R2HSL_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid, "valid after reset")

endmodule

bind rgb_to_hsl_converter r2hsl_checker u_r2hsl_checker (.*);

`default_nettype wire

// ===== bench/rgb_to_hsl_converter_tb.sv =====
// Self-checking bench for rgb_to_hsl_converter: directed and random ARGB pixels.
// Depends on r2hsl_pkg (field width, hue branch enum, hue and sum constants)
// and on the rgb_to_hsl_converter RTL.
`timescale 1ns / 1ps

module rgb_to_hsl_converter_tb;
    import r2hsl_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_PIXELS  = 1330;
    localparam int PHASE_LEN      = 450;    // transactions per idling phase
    localparam int LONG_STALL_AT  = 300;    // result count that starts the long stall
    localparam int LONG_STALL_LEN = 120;
    localparam int SETTLE_CYCLES  = 2 * PIPE_STAGES + 4;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam longint HUE_Q8   = 256;
    localparam longint ONE_Q16  = 65536;

    typedef struct {
        logic [31:0]        word;
        logic [FIELD_W-1:0] hue;
        logic [FIELD_W-1:0] sat;
        logic [FIELD_W-1:0] light;
    } t_hsl_result;

    typedef struct {
        logic [31:0] word;
        bit          drain_first;   // hold this pixel until the pipeline is empty
    } t_pixel_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [31:0]          i_argb_word = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [FIELD_W-1:0]   o_hue_deg_q8;
    logic [FIELD_W-1:0]   o_saturation_q16;
    logic [FIELD_W-1:0]   o_lightness_q16;

    t_pixel_item pixel_queue[$];
    t_hsl_result hsl_expected[$];

    int error_count   = 0;
    int pixels_in     = 0;
    int results_out   = 0;
    int grey_pixels   = 0;
    int wrapped_hues  = 0;
    int stall_left    = 0;
    bit long_stall_done = 1'b0;
    int quiet_cycles  = 0;

    rgb_to_hsl_converter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_argb_word      (i_argb_word),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_hue_deg_q8     (o_hue_deg_q8),
        .o_saturation_q16 (o_saturation_q16),
        .o_lightness_q16  (o_lightness_q16)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Convert one pixel to HSL with exact integer division. Alpha is dropped,
    // the branch follows the channel holding the maximum with red winning ties,
    // then green.
    function automatic t_hsl_result convert_pixel(logic [31:0] word);
        t_hsl_result res;
        longint red, grn, blu, mx, mn, delta, sum, den, num;
        t_branch branch;
        red = word[23:16];
        grn = word[15:8];
        blu = word[7:0];
        mx = red;
        if (grn > mx) mx = grn;
        if (blu > mx) mx = blu;
        mn = red;
        if (grn < mn) mn = grn;
        if (blu < mn) mn = blu;
        delta = mx - mn;
        sum = mx + mn;
        res.word  = word;
        res.light = FIELD_W'((sum * ONE_Q16) / longint'(SUM_FULL));
        res.sat   = '0;
        res.hue   = '0;
        if (delta != 0) begin
            den = (sum >= longint'(SUM_MID)) ? longint'(SUM_FULL) - sum : sum;
            res.sat = FIELD_W'((delta * ONE_Q16) / den);
            if (mx == red)      branch = BR_RED;
            else if (mx == grn) branch = BR_GREEN;
            else                branch = BR_BLUE;
            case (branch)
                BR_RED: begin
                    if (grn >= blu)
                        num = longint'(HUE_SLOPE) * HUE_Q8 * (grn - blu);
                    else
                        num = longint'(HUE_K_RED_WRAP) * HUE_Q8 * delta
                              - longint'(HUE_SLOPE) * HUE_Q8 * (blu - grn);
                end
                BR_GREEN: begin
                    num = longint'(HUE_K_GREEN) * HUE_Q8 * delta
                          + longint'(HUE_SLOPE) * HUE_Q8 * (blu - red);
                end
                default: begin
                    num = longint'(HUE_K_BLUE) * HUE_Q8 * delta
                          + longint'(HUE_SLOPE) * HUE_Q8 * (red - grn);
                end
            endcase
            res.hue = FIELD_W'(num / delta);
        end
        return res;
    endfunction

    // Idle percentage for the current phase: heavier stalls on the receiver
    // first, then on the sender, then full rate on both sides.
    function automatic int idle_pct(bit receiver);
        if (pixels_in < PHASE_LEN)          return receiver ? 66 : 31;
        else if (pixels_in < 2 * PHASE_LEN) return receiver ? 31 : 66;
        else                                return 0;
    endfunction

    // Random pixel, shaped to reach greys, near-greys, ties and channel extremes.
    function automatic logic [31:0] random_pixel();
        logic [7:0] ch[3];
        int base, pick, k;
        logic [7:0] corner[4];
        corner = '{8'd0, 8'd1, 8'd254, 8'd255};
        for (k = 0; k < 3; k++) ch[k] = 8'($urandom);
        case ($urandom_range(9))
            5, 6: begin
                // Near grey: small delta exercises tiny divisors
                base = $urandom_range(255);
                for (k = 0; k < 3; k++) begin
                    pick = base + int'($urandom_range(4)) - 2;
                    ch[k] = 8'((pick < 0) ? 0 : (pick > 255) ? 255 : pick);
                end
            end
            7: begin
                // Two channels tied, often at the maximum
                pick = $urandom_range(2);
                ch[(pick + 1) % 3] = ch[pick];
            end
            8: begin
                for (k = 0; k < 3; k++) ch[k] = corner[$urandom_range(3)];
            end
            9: begin
                ch[$urandom_range(2)] = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            default: ;
        endcase
        return {8'($urandom), ch[0], ch[1], ch[2]};
    endfunction

    task automatic add_pixel(logic [31:0] word, bit drain_first);
        t_pixel_item item;
        item.word = word;
        item.drain_first = drain_first;
        pixel_queue.push_back(item);
    endtask

    task automatic check_field(string field, logic [31:0] word,
                               logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch for pixel %08h: expected %0d, actual %0d",
                     $time, field, word, want, got);
        end
    endtask

    // Driver: record each accepted transaction, then hold or advance the payload.
    // Valid only drops when the current transaction was accepted.
    always @(posedge i_clk) begin
        t_hsl_result res;
        t_pixel_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                res = convert_pixel(i_argb_word);
                hsl_expected.push_back(res);
                pixels_in++;
                if (res.sat == 0) grey_pixels++;
                if (i_argb_word[23:16] >= i_argb_word[15:8] &&
                    i_argb_word[23:16] >= i_argb_word[7:0] &&
                    i_argb_word[15:8] < i_argb_word[7:0])
                    wrapped_hues++;
            end
            if (!i_valid || o_ready) begin
                if (pixel_queue.size() == 0 ||
                    (pixel_queue[0].drain_first && hsl_expected.size() != 0) ||
                    $urandom_range(99) < idle_pct(1'b0)) begin
                    i_valid <= 1'b0;
                end else begin
                    nxt = pixel_queue.pop_front();
                    i_valid <= 1'b1;
                    i_argb_word <= nxt.word;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction, then
    // choose the next ready. The long stall lets the pipeline fill and push back.
    always @(posedge i_clk) begin
        t_hsl_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_out++;
                if (hsl_expected.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result hue %0d sat %0d light %0d",
                             $time, o_hue_deg_q8, o_saturation_q16, o_lightness_q16);
                end else begin
                    want = hsl_expected.pop_front();
                    check_field("hue", want.word, want.hue, o_hue_deg_q8);
                    check_field("saturation", want.word, want.sat, o_saturation_q16);
                    check_field("lightness", want.word, want.light, o_lightness_q16);
                end
            end
            if (!long_stall_done && results_out == LONG_STALL_AT) begin
                long_stall_done = 1'b1;
                stall_left = LONG_STALL_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= idle_pct(1'b1));
            end
        end
    end

    // Watchdog: end the run when no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int n;
        // Directed: black, white, alpha only, primaries, secondaries with tied
        // maxima, grey, red-branch wrap, smallest saturation divisors, unit delta.
        add_pixel(32'h0000_0000, 1'b0);
        add_pixel(32'h00FF_FFFF, 1'b0);
        add_pixel(32'hFFFF_FFFF, 1'b0);
        add_pixel(32'hFF00_0000, 1'b0);
        add_pixel(32'h00FF_0000, 1'b0);
        add_pixel(32'h0000_FF00, 1'b0);
        add_pixel(32'h0000_00FF, 1'b0);
        add_pixel(32'h00FF_FF00, 1'b0);
        add_pixel(32'h0000_FFFF, 1'b0);
        add_pixel(32'h00FF_00FF, 1'b0);
        add_pixel(32'h8080_8080, 1'b0);
        add_pixel(32'h00FF_0080, 1'b0);
        add_pixel(32'h00FF_8000, 1'b0);
        add_pixel(32'h0020_C040, 1'b0);
        add_pixel(32'h0040_20C0, 1'b0);
        add_pixel(32'h0001_0000, 1'b0);
        add_pixel(32'h00FF_FEFE, 1'b0);
        add_pixel(32'h0080_7F7F, 1'b0);
        add_pixel(32'h007F_7F80, 1'b0);
        add_pixel(32'hA5C8_C864, 1'b0);
        add_pixel(32'h5A64_C8C8, 1'b0);
        add_pixel(32'h0080_8081, 1'b0);
        // Random stream; two pixels wait for the pipeline to drain first
        for (n = 0; n < RANDOM_PIXELS; n++)
            add_pixel(random_pixel(), (n == 0) || (n == RANDOM_PIXELS / 2));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pixel_queue.size() != 0 || i_valid || hsl_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (hsl_expected.size() != 0) begin
            error_count++;
            $display("%0t: %0d predicted results never arrived", $time,
                     hsl_expected.size());
        end
        $display("Converted %0d pixels into %0d HSL results, %0d mismatches.",
                 pixels_in, results_out, error_count);
        $display("Grey pixels: %0d, wrapped red-branch hues: %0d, long output stall: %0d.",
                 grey_pixels, wrapped_hues, long_stall_done);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/r2hsl_pkg.sv
rtl/core/r2hsl_extrema.sv
rtl/core/r2hsl_prep.sv
rtl/core/r2hsl_div_stage.sv
rtl/core/rgb_to_hsl_converter.sv
rtl/core/r2hsl_checker.sv
bench/rgb_to_hsl_converter_tb.sv
